>>> hw/rtl/tqla_pkg.sv
// ----------------------------------------------------------------------------
// tqla_pkg
// Shared types and constants of the tabular Q-learning agent: transaction
// payloads, item kinds, register map and register reset values.
// ----------------------------------------------------------------------------
package tqla_pkg;

  localparam int unsigned REG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_LEARN_RATE    = 3'd0,
    REG_DISCOUNT      = 3'd1,
    REG_EXPLORE_RATE  = 3'd2,
    REG_UPDATE_ENABLE = 3'd3,
    REG_ACTION_COUNT  = 3'd4
  } reg_idx_e;

  typedef enum logic {
    KIND_SELECT = 1'b0,
    KIND_LEARN  = 1'b1
  } kind_e;

  localparam logic [15:0] LEARN_RATE_RST    = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST      = 16'd58982;
  localparam logic [15:0] EXPLORE_RATE_RST  = 16'd6554;
  localparam logic        UPDATE_ENABLE_RST = 1'b1;
  localparam logic [4:0]  ACTION_COUNT_RST  = 5'd16;

  typedef struct packed {
    kind_e              kind;
    logic [5:0]         state_index;
    logic signed [31:0] reward;
    logic [15:0]        explore_draw;
    logic [3:0]         random_action;
    logic [15:0]        tie_bits;
  } tqla_in_t;

  typedef struct packed {
    logic [3:0]         chosen_action;
    logic               explored;
    logic signed [31:0] new_value;
    logic               table_written;
  } tqla_out_t;

endpackage

>>> hw/rtl/tqla_if.sv
// ----------------------------------------------------------------------------
// tqla_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface tqla_in_if
  import tqla_pkg::*;
();
  logic     valid;
  logic     ready;
  tqla_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tqla_out_if
  import tqla_pkg::*;
();
  logic      valid;
  logic      ready;
  tqla_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/tabular_q_learning_agent.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_agent
// Q-value table with epsilon-greedy action selection and Q-learning update.
// ----------------------------------------------------------------------------
// After reset the block sweeps all STATE_SLOTS * 2**clog2(ACTION_SLOTS)
// Q table entries (1024 by default) to zero, one entry per cycle, and takes
// no item meanwhile; register writes are taken as ever. It then works on
// one item at a time: an exploring select reads no table entry, a greedy
// select scans the n actions in use of its row, and a learn item scans its
// row, reads the old value and forms two products, or with updates off
// only reads the old value. The cost is set by the single table read port,
// which the row scan walks one entry per cycle, and by one shared multiplier
// that forms each fixed-point product in two byte-wide steps. A finished
// result waits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent
  import tqla_pkg::*;
#(
  parameter int unsigned STATE_SLOTS  = 64,
  parameter int unsigned ACTION_SLOTS = 16,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tqla_in_if.sink               in_i,
  tqla_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned SIW     = $clog2(STATE_SLOTS);
  localparam int unsigned AIW     = $clog2(ACTION_SLOTS);
  localparam int unsigned ADDR_W  = SIW + AIW;
  localparam int unsigned DEPTH   = STATE_SLOTS * (2 ** AIW);
  localparam int unsigned VB      = VALUE_BITS;
  localparam int unsigned MA      = VB + 1;
  localparam int unsigned PW      = MA + 9;
  localparam int unsigned ACC_W   = MA + 17;
  localparam int unsigned TW      = ((VB > 32) ? VB : 32) + 2;
  localparam int unsigned UW      = VB + 2;
  localparam int unsigned EW      = (VB > 32) ? VB : 32;
  localparam int unsigned ACT_LIM = (ACTION_SLOTS < 16) ? ACTION_SLOTS : 16;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_QREAD,
    S_QWAIT,
    S_MULH,
    S_MULL,
    S_TARGET,
    S_UPDATE,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [ADDR_W-1:0]      clr_addr_q;
  kind_e                  kind_q;
  logic [SIW-1:0]         row_q;
  logic signed [31:0]     reward_q;
  logic [15:0]            ties_q;
  logic [4:0]             n_q;
  logic [4:0]             cnt_q;
  logic                   cmp_v_q;
  logic [3:0]             cmp_idx_q;
  logic signed [VB-1:0]   best_val_q;
  logic [3:0]             best_idx_q;
  logic signed [VB-1:0]   q_q;
  logic signed [MA-1:0]   mul_a_q;
  logic [15:0]            frac_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                   phase_q;
  logic [3:0]             res_action_q;
  logic                   res_explored_q;
  logic signed [31:0]     res_value_q;
  logic                   res_written_q;
  logic                   out_valid_q;
  tqla_out_t              out_data_q;
  logic [SIW-1:0]         last_state_q;
  logic [AIW-1:0]         last_action_q;

  logic [15:0]            learn_rate_q;
  logic [15:0]            discount_q;
  logic [15:0]            explore_rate_q;
  logic                   update_enable_q;
  logic [4:0]             action_count_q;

  logic signed [VB-1:0]   mem [DEPTH];
  logic signed [VB-1:0]   rd_data_q;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic signed [VB-1:0]   mem_wdata;
  logic [ADDR_W-1:0]      mem_raddr;

  logic [SIW-1:0]         st_mod;
  logic [4:0]             n_cfg;
  logic [3:0]             rnd_clamp;
  logic                   explore_hit;
  logic                   take;
  logic                   cfg_we;
  logic [7:0]             mul_byte;
  logic signed [PW-1:0]   prod;
  logic signed [MA-1:0]   mul_res;
  logic signed [TW-1:0]   tgt_sum;
  logic [TW-VB:0]         tgt_hi;
  logic signed [VB-1:0]   tgt_sat;
  logic signed [MA-1:0]   diff;
  logic signed [UW-1:0]   upd_sum;
  logic [UW-VB:0]         upd_hi;
  logic signed [VB-1:0]   upd_sat;

  // Saturate a table value to the 32-bit result field.
  function automatic logic signed [31:0] to_word(input logic signed [VB-1:0] v);
    logic signed [EW-1:0] ext;
    logic [EW-32:0]       hi;
    ext = EW'(v);
    hi  = ext[EW-1:31];
    if ((&hi) || !(|hi)) begin
      to_word = ext[31:0];
    end else if (ext[EW-1]) begin
      to_word = 32'sh8000_0000;
    end else begin
      to_word = 32'sh7FFF_FFFF;
    end
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;
  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite;

  always_comb begin
    st_mod = '0;
    for (int k = 0; k < 64; k++) begin
      if (in_i.data.state_index == 6'(k)) begin
        st_mod = SIW'(k % STATE_SLOTS);
      end
    end
  end

  always_comb begin
    if (action_count_q == 5'd0) begin
      n_cfg = 5'd1;
    end else if (action_count_q > 5'(ACT_LIM)) begin
      n_cfg = 5'(ACT_LIM);
    end else begin
      n_cfg = action_count_q;
    end
    rnd_clamp   = ({1'b0, in_i.data.random_action} < n_cfg) ? in_i.data.random_action
                                                             : 4'(n_cfg - 5'd1);
    explore_hit = (in_i.data.explore_draw < explore_rate_q);
  end

  // Row scan: a strictly larger value wins, an equal one on its tie bit.
  assign take = (cmp_idx_q == 4'd0) || (rd_data_q > best_val_q) ||
                ((rd_data_q == best_val_q) && ties_q[cmp_idx_q]);

  // Shared multiplier: value times one byte of the Q0.16 fraction.
  assign mul_byte = (state_q == S_MULH) ? frac_q[15:8] : frac_q[7:0];
  assign prod     = mul_a_q * $signed({1'b0, mul_byte});
  assign mul_res  = acc_q[16 +: MA];

  always_comb begin
    tgt_sum = TW'(reward_q) + TW'(mul_res);
    tgt_hi  = tgt_sum[TW-1:VB-1];
    if ((&tgt_hi) || !(|tgt_hi)) begin
      tgt_sat = tgt_sum[VB-1:0];
    end else if (tgt_sum[TW-1]) begin
      tgt_sat = {1'b1, {(VB-1){1'b0}}};
    end else begin
      tgt_sat = {1'b0, {(VB-1){1'b1}}};
    end
    diff    = MA'(tgt_sat) - MA'(q_q);

    upd_sum = UW'(q_q) + UW'(mul_res);
    upd_hi  = upd_sum[UW-1:VB-1];
    if ((&upd_hi) || !(|upd_hi)) begin
      upd_sat = upd_sum[VB-1:0];
    end else if (upd_sum[UW-1]) begin
      upd_sat = {1'b1, {(VB-1){1'b0}}};
    end else begin
      upd_sat = {1'b0, {(VB-1){1'b1}}};
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {last_state_q, last_action_q};
    mem_wdata = upd_sat;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (state_q == S_UPDATE) begin
      mem_we    = 1'b1;
    end
    if (state_q == S_QREAD) begin
      mem_raddr = {last_state_q, last_action_q};
    end else begin
      mem_raddr = {row_q, AIW'(cnt_q)};
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_LEARN_RATE:    prdata = {16'd0, learn_rate_q};
      REG_DISCOUNT:      prdata = {16'd0, discount_q};
      REG_EXPLORE_RATE:  prdata = {16'd0, explore_rate_q};
      REG_UPDATE_ENABLE: prdata = {31'd0, update_enable_q};
      REG_ACTION_COUNT:  prdata = {27'd0, action_count_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      clr_addr_q      <= '0;
      kind_q          <= KIND_SELECT;
      row_q           <= '0;
      reward_q        <= '0;
      ties_q          <= '0;
      n_q             <= '0;
      cnt_q           <= '0;
      cmp_v_q         <= 1'b0;
      cmp_idx_q       <= '0;
      best_val_q      <= '0;
      best_idx_q      <= '0;
      q_q             <= '0;
      mul_a_q         <= '0;
      frac_q          <= '0;
      acc_q           <= '0;
      phase_q         <= 1'b0;
      res_action_q    <= '0;
      res_explored_q  <= 1'b0;
      res_value_q     <= '0;
      res_written_q   <= 1'b0;
      out_valid_q     <= 1'b0;
      out_data_q      <= '0;
      last_state_q    <= '0;
      last_action_q   <= '0;
      learn_rate_q    <= LEARN_RATE_RST;
      discount_q      <= DISCOUNT_RST;
      explore_rate_q  <= EXPLORE_RATE_RST;
      update_enable_q <= UPDATE_ENABLE_RST;
      action_count_q  <= ACTION_COUNT_RST;
    end else begin
      if (cfg_we) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_LEARN_RATE:    learn_rate_q    <= pwdata[15:0];
          REG_DISCOUNT:      discount_q      <= pwdata[15:0];
          REG_EXPLORE_RATE:  explore_rate_q  <= pwdata[15:0];
          REG_UPDATE_ENABLE: update_enable_q <= pwdata[0];
          REG_ACTION_COUNT:  action_count_q  <= pwdata[4:0];
          default: ;
        endcase
      end

      // Drop the result once taken; S_DONE loads the next one itself.
      if (out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            kind_q   <= in_i.data.kind;
            ties_q   <= in_i.data.tie_bits;
            reward_q <= in_i.data.reward;
            n_q      <= n_cfg;
            cnt_q    <= '0;
            cmp_v_q  <= 1'b0;
            row_q    <= st_mod;
            if (in_i.data.kind == KIND_SELECT) begin
              if (explore_hit) begin
                res_action_q   <= rnd_clamp;
                res_explored_q <= 1'b1;
                res_value_q    <= '0;
                res_written_q  <= 1'b0;
                last_state_q   <= st_mod;
                last_action_q  <= AIW'(rnd_clamp);
                state_q        <= S_DONE;
              end else begin
                state_q <= S_SCAN;
              end
            end else if (update_enable_q) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_QREAD;
            end
          end
        end

        S_SCAN: begin
          if (cnt_q < n_q) begin
            cnt_q     <= cnt_q + 5'd1;
            cmp_v_q   <= 1'b1;
            cmp_idx_q <= cnt_q[3:0];
          end else begin
            cmp_v_q <= 1'b0;
          end
          if (cmp_v_q && take) begin
            best_val_q <= rd_data_q;
            best_idx_q <= cmp_idx_q;
          end
          if ((cnt_q == n_q) && !cmp_v_q) begin
            if (kind_q == KIND_SELECT) begin
              res_action_q   <= best_idx_q;
              res_explored_q <= 1'b0;
              res_value_q    <= '0;
              res_written_q  <= 1'b0;
              last_state_q   <= row_q;
              last_action_q  <= AIW'(best_idx_q);
              state_q        <= S_DONE;
            end else begin
              state_q <= S_QREAD;
            end
          end
        end

        S_QREAD: begin
          state_q <= S_QWAIT;
        end

        S_QWAIT: begin
          q_q <= rd_data_q;
          if (update_enable_q) begin
            mul_a_q <= MA'(best_val_q);
            frac_q  <= discount_q;
            phase_q <= 1'b0;
            state_q <= S_MULH;
          end else begin
            res_action_q   <= 4'(last_action_q);
            res_explored_q <= 1'b0;
            res_value_q    <= to_word(rd_data_q);
            res_written_q  <= 1'b0;
            state_q        <= S_DONE;
          end
        end

        S_MULH: begin
          acc_q   <= ACC_W'(prod) <<< 8;
          state_q <= S_MULL;
        end

        S_MULL: begin
          acc_q   <= acc_q + ACC_W'(prod);
          state_q <= phase_q ? S_UPDATE : S_TARGET;
        end

        S_TARGET: begin
          mul_a_q <= diff;
          frac_q  <= learn_rate_q;
          phase_q <= 1'b1;
          state_q <= S_MULH;
        end

        S_UPDATE: begin
          res_action_q   <= 4'(last_action_q);
          res_explored_q <= 1'b0;
          res_value_q    <= to_word(upd_sat);
          res_written_q  <= 1'b1;
          state_q        <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q              <= 1'b1;
            out_data_q.chosen_action <= res_action_q;
            out_data_q.explored      <= res_explored_q;
            out_data_q.new_value     <= res_value_q;
            out_data_q.table_written <= res_written_q;
            state_q                  <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_tabular_q_learning_agent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tabular_q_learning_agent
// Self-checking bench for the tabular Q-learning agent. A scoreboard class
// keeps its own Q table, last state/action and register copies, predicts
// the result of every accepted item and compares results field by field.
// Directed items cover greedy ties, exploring, clamping, saturation and
// disabled updates; random select/learn episodes follow under many register
// settings, with random stalls on both channels in all but the last phase.
// ----------------------------------------------------------------------------
module tb_tabular_q_learning_agent
  import tqla_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 153;
  localparam int RANDOM_PHASES  = 10;

  class agent_scoreboard;
    longint      q_tab [1024];
    logic [5:0]  prev_state;
    logic [3:0]  prev_action;
    logic [15:0] alpha;
    logic [15:0] gamma;
    logic [15:0] epsilon;
    logic        upd_en;
    logic [4:0]  act_cnt;
    tqla_out_t   awaited[$];
    int          mismatches;
    int          compared;
    int          n_select;
    int          n_learn;
    int          n_explored;
    int          n_written;

    function new();
      foreach (q_tab[i]) q_tab[i] = 0;
      prev_state  = '0;
      prev_action = '0;
      alpha       = LEARN_RATE_RST;
      gamma       = DISCOUNT_RST;
      epsilon     = EXPLORE_RATE_RST;
      upd_en      = UPDATE_ENABLE_RST;
      act_cnt     = ACTION_COUNT_RST;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_LEARN_RATE:    alpha   = val[15:0];
        REG_DISCOUNT:      gamma   = val[15:0];
        REG_EXPLORE_RATE:  epsilon = val[15:0];
        REG_UPDATE_ENABLE: upd_en  = val[0];
        REG_ACTION_COUNT:  act_cnt = val[4:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // floor(v * f / 2^16) for an unsigned Q0.16 fraction
    function longint scale_frac(longint v, logic [15:0] f);
      longint p;
      p = v * longint'(f);
      return p >>> 16;
    endfunction

    function void note_item(tqla_in_t it);
      int unsigned n;
      int unsigned best;
      int          row;
      int          cell_idx;
      longint      bv;
      longint      v;
      longint      cur;
      longint      mx;
      longint      target;
      longint      delta;
      longint      newv;
      tqla_out_t   res;
      n   = (act_cnt == 0) ? 1 : ((act_cnt > 16) ? 16 : act_cnt);
      res = '0;
      res.chosen_action = prev_action;
      row = int'(it.state_index) * 16;
      if (it.kind == KIND_SELECT) begin
        n_select++;
        if (it.explore_draw < epsilon) begin
          res.chosen_action = (it.random_action < n) ? it.random_action : 4'(n - 1);
          res.explored      = 1'b1;
          n_explored++;
        end else begin
          best = 0;
          bv   = q_tab[row];
          for (int unsigned i = 1; i < n; i++) begin
            v = q_tab[row + i];
            if (v > bv || (v == bv && it.tie_bits[i])) begin
              best = i;
              bv   = v;
            end
          end
          res.chosen_action = 4'(best);
        end
        prev_state  = it.state_index;
        prev_action = res.chosen_action;
      end else begin
        n_learn++;
        cell_idx = int'(prev_state) * 16 + int'(prev_action);
        cur      = q_tab[cell_idx];
        newv     = cur;
        if (upd_en) begin
          mx = q_tab[row];
          for (int unsigned i = 1; i < n; i++)
            if (q_tab[row + i] > mx) mx = q_tab[row + i];
          target = clip32(longint'($signed(it.reward)) + scale_frac(mx, gamma));
          delta  = scale_frac(target - cur, alpha);
          newv   = clip32(cur + delta);
          q_tab[cell_idx]   = newv;
          res.table_written = 1'b1;
          n_written++;
        end
        res.new_value = 32'(newv);
      end
      awaited = {awaited, res};
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 50)
        $display("%0t: result %0d %s got %h want %h", $time, compared, field, got, want);
    endtask

    task check_result(tqla_out_t got);
      tqla_out_t want;
      if (awaited.size() == 0) begin
        report("unexpected result, chosen_action", 32'(got.chosen_action), '0);
        return;
      end
      want = awaited.pop_front();
      if (got.chosen_action !== want.chosen_action)
        report("chosen_action", 32'(got.chosen_action), 32'(want.chosen_action));
      if (got.explored !== want.explored)
        report("explored", 32'(got.explored), 32'(want.explored));
      if (got.new_value !== want.new_value)
        report("new_value", got.new_value, want.new_value);
      if (got.table_written !== want.table_written)
        report("table_written", 32'(got.table_written), 32'(want.table_written));
      compared++;
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  tqla_in_if  in_ch ();
  tqla_out_if out_ch ();

  agent_scoreboard sb = new();

  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;
  int settings_used;
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  tabular_q_learning_agent DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Accepted transactions on both channels, plus the watchdog.
  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      sb.note_item(in_ch.data);
      moved = 1'b1;
    end
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result(out_ch.data);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result receiver: random stall bursts and one long hold-off on request.
  initial begin : result_sink
    int gap;
    int hold_left;
    gap       = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(tqla_in_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic close_phase();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Back-to-back writes go from access straight into the next setup.
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [15:0] a, logic [15:0] g, logic [15:0] e,
                           logic en, logic [4:0] cnt);
    write_reg(REG_LEARN_RATE, 32'(a));
    write_reg(REG_DISCOUNT, 32'(g));
    write_reg(REG_EXPLORE_RATE, 32'(e));
    write_reg(REG_UPDATE_ENABLE, 32'(en));
    write_reg(REG_ACTION_COUNT, 32'(cnt));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
    @(posedge clk_i);
  endtask

  function automatic tqla_in_t mk_item(kind_e k, logic [5:0] st, logic [31:0] r,
                                       logic [15:0] draw, logic [3:0] ra,
                                       logic [15:0] ties);
    tqla_in_t it;
    it.kind          = k;
    it.state_index   = st;
    it.reward        = r;
    it.explore_draw  = draw;
    it.random_action = ra;
    it.tie_bits      = ties;
    return it;
  endfunction

  // Keep most visits in a few states so values build up and ties break.
  function automatic logic [5:0] pick_state();
    if ($urandom_range(0, 9) < 7) return 6'($urandom_range(0, 7));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic tqla_in_t make_item(kind_e k, logic [5:0] st);
    logic [31:0] r;
    logic [15:0] draw;
    logic [15:0] ties;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: r = 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      6:                r = 32'h7FFF_FFFF;
      7:                r = 32'h8000_0000;
      default:          r = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       draw = 16'h0000;
      1:       draw = 16'hFFFF;
      default: draw = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       ties = 16'h0000;
      1:       ties = 16'hFFFF;
      default: ties = 16'($urandom_range(0, 65535));
    endcase
    return mk_item(k, st, r, draw, 4'($urandom_range(0, 15)), ties);
  endfunction

  // Mostly select/learn episodes chained through the next state; the rest is noise.
  task automatic run_random(int count);
    int         sent;
    logic [5:0] cur_state;
    logic [5:0] next_state;
    sent      = 0;
    cur_state = pick_state();
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        next_state = pick_state();
        push_item(make_item(KIND_SELECT, cur_state));
        push_item(make_item(KIND_LEARN, next_state));
        cur_state = next_state;
        sent += 2;
      end else begin
        push_item(make_item(kind_e'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
        sent++;
      end
    end
    close_phase();
  endtask

  initial begin : stimulus
    logic [4:0]  cnt;
    logic [15:0] eps;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, empty table: ties, explore threshold, extreme rewards.
    push_item(mk_item(KIND_SELECT, 6'd0, 32'h0, 16'hFFFF, 4'd0, 16'h0000));
    push_item(mk_item(KIND_SELECT, 6'd0, 32'h0, 16'hFFFF, 4'd0, 16'hFFFF));
    push_item(mk_item(KIND_SELECT, 6'd63, 32'h0, 16'h0000, 4'd15, 16'h0000));
    push_item(mk_item(KIND_LEARN, 6'd63, 32'h7FFF_FFFF, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_SELECT, 6'd63, 32'h0, 16'hFFFF, 4'd0, 16'h0000));
    push_item(mk_item(KIND_LEARN, 6'd63, 32'h0, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_SELECT, 6'd5, 32'h0, 16'd6553, 4'd3, 16'h0000));
    push_item(mk_item(KIND_SELECT, 6'd5, 32'h0, 16'd6554, 4'd0, 16'h0100));
    push_item(mk_item(KIND_LEARN, 6'd0, 32'h8000_0000, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_SELECT, 6'd5, 32'h0, 16'hFFFF, 4'd0, 16'hFFFF));
    close_phase();

    // Full-scale alpha and gamma, no exploring: drive the target into saturation.
    configure(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 5'd16);
    push_item(mk_item(KIND_SELECT, 6'd63, 32'h0, 16'h0000, 4'd0, 16'h0000));
    push_item(mk_item(KIND_LEARN, 6'd63, 32'h7FFF_FFFF, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_LEARN, 6'd63, 32'h7FFF_FFFF, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_SELECT, 6'd10, 32'h0, 16'h0000, 4'd0, 16'h0000));
    push_item(mk_item(KIND_LEARN, 6'd10, 32'h8000_0000, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_LEARN, 6'd10, 32'h8000_0000, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_SELECT, 6'd10, 32'h0, 16'hFFFF, 4'd0, 16'hAAAA));
    close_phase();

    // Updates off, zero action count: one action, clamped exploring.
    configure(16'd6554, 16'd58982, 16'h8000, 1'b0, 5'd0);
    push_item(mk_item(KIND_SELECT, 6'd63, 32'h0, 16'hFFFF, 4'd0, 16'hFFFF));
    push_item(mk_item(KIND_SELECT, 6'd3, 32'h0, 16'h0000, 4'd15, 16'h0000));
    push_item(mk_item(KIND_LEARN, 6'd63, 32'h7FFF_FFFF, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_LEARN, 6'd0, 32'h0, 16'h0, 4'd0, 16'h0));
    close_phase();

    // Action count above the slot count, zero discount.
    configure(16'h8000, 16'h0000, 16'hFFFF, 1'b1, 5'd20);
    push_item(mk_item(KIND_SELECT, 6'd1, 32'h0, 16'hFFFE, 4'd15, 16'h0000));
    push_item(mk_item(KIND_SELECT, 6'd1, 32'h0, 16'hFFFF, 4'd0, 16'hFFFF));
    push_item(mk_item(KIND_LEARN, 6'd2, 32'h0001_0000, 16'h0, 4'd0, 16'h0));
    push_item(mk_item(KIND_LEARN, 6'd2, 32'hFFFF_0000, 16'h0, 4'd0, 16'h0));
    close_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       cnt = 5'd0;
        1:       cnt = 5'd1;
        2:       cnt = 5'd16;
        3:       cnt = 5'd31;
        default: cnt = 5'($urandom_range(0, 31));
      endcase
      eps = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 20000));
      if (p == 0)
        configure(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 5'd31);
      else if (p == 1)
        configure(16'd6554, 16'd58982, 16'd6554, 1'b1, 5'd2);
      else
        configure(pick_frac(), pick_frac(), eps, $urandom_range(0, 4) != 0, cnt);
      // Hold the result side long enough for the block to back up its input.
      if (p == 3) hold_req = 1'b1;
      if (p == RANDOM_PHASES - 1) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      run_random(PHASE_ITEMS);
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d select and %0d learn transactions under %0d register settings",
             sb.n_select, sb.n_learn, settings_used + 1);
    $display("%0d exploring picks, %0d table updates, %0d results compared",
             sb.n_explored, sb.n_written, sb.compared);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> tabular_q_learning_agent.f
hw/rtl/tqla_pkg.sv
hw/rtl/tqla_if.sv
hw/rtl/tabular_q_learning_agent.sv
tb/tb_tabular_q_learning_agent.sv
